// ----- rtl/kls_pkg.sv -----
// ----------------------------------------------------------------------------
// kls_pkg
// Shared types, token codes and character classes for the keyword lexer.
// ----------------------------------------------------------------------------
package kls_pkg;

	// Widths of the position counters and of the result fields.
	localparam int POS_BITS = 16;
	localparam int KIND_W   = 5;
	localparam int OFS_W    = 16;
	localparam int LEN_W    = 16;
	localparam int NUM_KW   = 7;
	localparam int KW_MAXC  = 6;

	// Depth of the result queue; two results may enter in one cycle.
	localparam int OUT_DEPTH = 4;
	localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
	localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

	localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};
	localparam logic [LEN_W-1:0]    LEN_MAX = {LEN_W{1'b1}};

	// Token kinds.
	localparam logic [KIND_W-1:0] KIND_IDENT  = 5'd0;
	localparam logic [KIND_W-1:0] KIND_NUMBER = 5'd1;
	localparam logic [KIND_W-1:0] KIND_KW0    = 5'd2;
	localparam logic [KIND_W-1:0] KIND_ARROW  = 5'd9;
	localparam logic [KIND_W-1:0] KIND_MINUS  = 5'd10;
	localparam logic [KIND_W-1:0] KIND_LPAREN = 5'd11;
	localparam logic [KIND_W-1:0] KIND_RPAREN = 5'd12;
	localparam logic [KIND_W-1:0] KIND_LBRACE = 5'd13;
	localparam logic [KIND_W-1:0] KIND_RBRACE = 5'd14;
	localparam logic [KIND_W-1:0] KIND_EQUAL  = 5'd15;
	localparam logic [KIND_W-1:0] KIND_COLON  = 5'd16;
	localparam logic [KIND_W-1:0] KIND_PLUS   = 5'd17;
	localparam logic [KIND_W-1:0] KIND_SEMI   = 5'd18;
	localparam logic [KIND_W-1:0] KIND_ERROR  = 5'd19;
	localparam logic [KIND_W-1:0] KIND_END    = 5'd20;

	// Keyword spellings, one character per entry; entries past the length are unused.
	localparam logic [7:0] KW_TEXT [NUM_KW][KW_MAXC] = '{
		'{"f", "u", "n", "c", 8'h00, 8'h00},
		'{"r", "e", "t", "u", "r", "n"},
		'{"v", "a", "r", 8'h00, 8'h00, 8'h00},
		'{"i", "3", "2", 8'h00, 8'h00, 8'h00},
		'{"b", "o", "o", "l", 8'h00, 8'h00},
		'{"t", "r", "u", "e", 8'h00, 8'h00},
		'{"f", "a", "l", "s", "e", 8'h00}
	};
	localparam logic [2:0] KW_LEN [NUM_KW] = '{3'd4, 3'd6, 3'd3, 3'd3, 3'd4, 3'd4, 3'd5};

	// One result word.
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [OFS_W-1:0]  start;
		logic [LEN_W-1:0]  length;
		logic              last;
	} result_t;

	// Results produced by one byte, first in r0.
	typedef struct packed {
		logic [1:0] count;
		result_t    r0;
		result_t    r1;
	} push_t;

	function automatic result_t mk_result(logic [KIND_W-1:0] kind, logic [OFS_W-1:0] start,
			logic [LEN_W-1:0] length, logic last);
		result_t r;
		r.kind   = kind;
		r.start  = start;
		r.length = length;
		r.last   = last;
		return r;
	endfunction

	// Offsets in results are the low bits of the position.
	function automatic logic [OFS_W-1:0] to_start(logic [POS_BITS-1:0] pos);
		logic [31:0] w;
		w = 32'(pos);
		return w[OFS_W-1:0];
	endfunction

	function automatic logic is_alpha(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_digit(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_space(logic [7:0] c);
		return c == " " || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic is_word(logic [7:0] c);
		return is_alpha(c) || is_digit(c) || c == "_";
	endfunction

	// Kind of a single-character symbol; error for anything else.
	function automatic logic [KIND_W-1:0] sym_kind(logic [7:0] c);
		logic [KIND_W-1:0] k;
		case (c)
			"(":     k = KIND_LPAREN;
			")":     k = KIND_RPAREN;
			"{":     k = KIND_LBRACE;
			"}":     k = KIND_RBRACE;
			"=":     k = KIND_EQUAL;
			":":     k = KIND_COLON;
			"+":     k = KIND_PLUS;
			";":     k = KIND_SEMI;
			default: k = KIND_ERROR;
		endcase
		return k;
	endfunction

	// Keep the keywords whose character at index wl matches c.
	function automatic logic [NUM_KW-1:0] narrow(logic [NUM_KW-1:0] cand,
			logic [LEN_W-1:0] wl, logic [7:0] c);
		logic [NUM_KW-1:0] m;
		m = '0;
		for (int i = 0; i < NUM_KW; i++) begin
			if (cand[i] && wl < LEN_W'(KW_LEN[i]) && KW_TEXT[i][wl[2:0]] == c) begin
				m[i] = 1'b1;
			end
		end
		return m;
	endfunction

	// Kind of a finished word: a keyword if a candidate of that length survives.
	function automatic logic [KIND_W-1:0] word_kind(logic [NUM_KW-1:0] cand,
			logic [LEN_W-1:0] wl);
		logic [KIND_W-1:0] k;
		k = KIND_IDENT;
		for (int i = 0; i < NUM_KW; i++) begin
			if (cand[i] && wl == LEN_W'(KW_LEN[i])) begin
				k = KIND_KW0 + KIND_W'(i);
			end
		end
		return k;
	endfunction

endpackage

// ----- rtl/kls_if.sv -----
// ----------------------------------------------------------------------------
// kls_if
// Valid/ready channels for source bytes and for token results.
// ----------------------------------------------------------------------------
interface kls_in_if;
	import kls_pkg::*;

	logic       valid;
	logic       ready;
	logic [7:0] byte_in;
	logic       end_of_text;

	modport source (output valid, output byte_in, output end_of_text, input ready);
	modport sink (input valid, input byte_in, input end_of_text, output ready);
endinterface

interface kls_out_if;
	import kls_pkg::*;

	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] token_kind;
	logic [OFS_W-1:0]  token_start;
	logic [LEN_W-1:0]  token_length;
	logic              last_result;

	modport source (output valid, output token_kind, output token_start,
		output token_length, output last_result, input ready);
	modport sink (input valid, input token_kind, input token_start,
		input token_length, input last_result, output ready);
endinterface

// ----- rtl/keyword_lexer_stream.sv -----
// ----------------------------------------------------------------------------
// keyword_lexer_stream
// Streaming lexer: one source byte in, tokens out as kind, offset and length.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle while input is not stalled. A
// byte is held in an input register while the scanner closes or extends the
// current token, and its results enter a four-word queue; a result is offered
// on the output from the queue, once its byte has left the input register.
// Words, numbers and a lone '-' are only reported when the byte after them
// arrives or at end of text, so one byte may give two results; the queue
// drains one per cycle while the output is ready, and input stalls only while
// it holds more than two words. A stream that yields one result per byte or
// fewer runs at a full byte per cycle while the output is always ready.
module keyword_lexer_stream (
	input  logic      clk,
	input  logic      arst_n,
	kls_in_if.sink    text,
	kls_out_if.source tokens
);
	import kls_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eot_s1;
	logic       space_ok;
	logic       step;
	push_t      push;

	assign step       = valid_s1 && space_ok;
	assign text.ready = !valid_s1 || space_ok;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.ready && text.valid) begin
			byte_s1 <= text.byte_in;
			eot_s1  <= text.end_of_text;
		end
	end

	kls_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.byte_s1 (byte_s1),
		.eot_s1  (eot_s1),
		.push    (push)
	);

	kls_out_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.space_ok (space_ok),
		.tokens   (tokens)
	);

endmodule

// ----- rtl/kls_core.sv -----
// ----------------------------------------------------------------------------
// kls_core
// Scanner state and the per-byte step: closes pending tokens, starts new ones
// and produces up to two results for each byte.
// ----------------------------------------------------------------------------
module kls_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  logic [7:0]    byte_s1,
	input  logic          eot_s1,
	output kls_pkg::push_t push
);
	import kls_pkg::*;

	localparam logic [2:0] MODE_IDLE   = 3'd0;
	localparam logic [2:0] MODE_WORD   = 3'd1;
	localparam logic [2:0] MODE_NUMBER = 3'd2;
	localparam logic [2:0] MODE_MINUS  = 3'd3;
	localparam logic [2:0] MODE_ERROR  = 3'd4;

	logic [2:0]          mode_q, mode_n;
	logic [POS_BITS-1:0] pos_q, pos_n, pos_inc;
	logic [POS_BITS-1:0] tb_q, tb_n;
	logic [NUM_KW-1:0]   cand_q, cand_n;
	logic [LEN_W-1:0]    wl_q, wl_n, wl_inc;
	logic                do_start;
	logic                a_v, b_v;
	result_t             a_res, b_res;
	logic [KIND_W-1:0]   kind_sym;

	// A pending word, number or minus, reported as it stands in the given state.
	function automatic logic pending(logic [2:0] mode);
		return mode == MODE_WORD || mode == MODE_NUMBER || mode == MODE_MINUS;
	endfunction

	function automatic result_t flush(logic [2:0] mode, logic [NUM_KW-1:0] cand,
			logic [LEN_W-1:0] wl, logic [POS_BITS-1:0] tb);
		result_t r;
		if (mode == MODE_WORD) begin
			r = mk_result(word_kind(cand, wl), to_start(tb), wl, 1'b0);
		end else if (mode == MODE_NUMBER) begin
			r = mk_result(KIND_NUMBER, to_start(tb), wl, 1'b0);
		end else begin
			r = mk_result(KIND_MINUS, to_start(tb), LEN_W'(1), 1'b0);
		end
		return r;
	endfunction

	assign pos_inc  = (pos_q == POS_MAX) ? pos_q : pos_q + 1'b1;
	assign wl_inc   = (wl_q == LEN_MAX) ? wl_q : wl_q + 1'b1;
	assign kind_sym = sym_kind(byte_s1);

	// Next state and results for the byte in the input register.
	always_comb begin
		mode_n   = mode_q;
		tb_n     = tb_q;
		cand_n   = cand_q;
		wl_n     = wl_q;
		pos_n    = pos_inc;
		do_start = 1'b0;
		a_v      = 1'b0;
		b_v      = 1'b0;
		a_res    = flush(mode_q, cand_q, wl_q, tb_q);
		b_res    = mk_result(KIND_ERROR, to_start(pos_q), LEN_W'(1), 1'b1);

		// Extend or close the token in progress.
		unique case (mode_q)
			MODE_WORD: begin
				if (is_word(byte_s1)) begin
					cand_n = narrow(cand_q, wl_q, byte_s1);
					wl_n   = wl_inc;
				end else begin
					a_v      = 1'b1;
					do_start = 1'b1;
				end
			end
			MODE_NUMBER: begin
				if (is_digit(byte_s1)) begin
					wl_n = wl_inc;
				end else begin
					a_v      = 1'b1;
					do_start = 1'b1;
				end
			end
			MODE_MINUS: begin
				if (byte_s1 == ">") begin
					a_v    = 1'b1;
					a_res  = mk_result(KIND_ARROW, to_start(tb_q), LEN_W'(2), 1'b0);
					mode_n = MODE_IDLE;
				end else begin
					a_v      = 1'b1;
					do_start = 1'b1;
				end
			end
			MODE_ERROR: begin
			end
			default: begin
				do_start = 1'b1;
			end
		endcase

		// The byte opens a token, emits a symbol, is skipped as a blank, or is an error.
		if (do_start) begin
			mode_n = MODE_IDLE;
			if (!is_space(byte_s1)) begin
				tb_n = pos_q;
				if (is_alpha(byte_s1) || byte_s1 == "_") begin
					mode_n = MODE_WORD;
					cand_n = narrow({NUM_KW{1'b1}}, '0, byte_s1);
					wl_n   = LEN_W'(1);
				end else if (is_digit(byte_s1)) begin
					mode_n = MODE_NUMBER;
					wl_n   = LEN_W'(1);
				end else if (byte_s1 == "-") begin
					mode_n = MODE_MINUS;
				end else if (kind_sym != KIND_ERROR) begin
					b_v   = 1'b1;
					b_res = mk_result(kind_sym, to_start(pos_q), LEN_W'(1), 1'b0);
				end else begin
					b_v    = 1'b1;
					mode_n = MODE_ERROR;
				end
			end
		end

		// End of text reports what is pending, marks the final result and resets.
		if (eot_s1) begin
			if (mode_n != MODE_ERROR) begin
				if (pending(mode_n)) begin
					b_v   = 1'b1;
					b_res = flush(mode_n, cand_n, wl_n, tb_n);
				end
				if (!a_v && !b_v) begin
					b_v   = 1'b1;
					b_res = mk_result(KIND_END, to_start(pos_inc), '0, 1'b1);
				end else if (b_v) begin
					b_res.last = 1'b1;
				end else begin
					a_res.last = 1'b1;
				end
			end
			mode_n = MODE_IDLE;
			pos_n  = '0;
			tb_n   = '0;
			cand_n = {NUM_KW{1'b1}};
			wl_n   = '0;
		end
	end

	// Pack the results, first one in r0.
	always_comb begin
		push.count = step ? {a_v & b_v, a_v ^ b_v} : 2'd0;
		push.r0    = a_v ? a_res : b_res;
		push.r1    = b_res;
	end

	// Scanner state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			pos_q  <= '0;
			tb_q   <= '0;
			cand_q <= {NUM_KW{1'b1}};
			wl_q   <= '0;
		end else if (step) begin
			mode_q <= mode_n;
			pos_q  <= pos_n;
			tb_q   <= tb_n;
			cand_q <= cand_n;
			wl_q   <= wl_n;
		end
	end

endmodule

// ----- rtl/kls_out_fifo.sv -----
// ----------------------------------------------------------------------------
// kls_out_fifo
// Small result queue that takes up to two results a cycle and hands out one.
// ----------------------------------------------------------------------------
module kls_out_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  kls_pkg::push_t push,
	output logic           space_ok,
	kls_out_if.source      tokens
);
	import kls_pkg::*;

	result_t              entry_q [OUT_DEPTH];
	logic [OUT_PTR_W-1:0] wr_q, rd_q;
	logic [OUT_CNT_W-1:0] count_q;
	logic                 pop;
	logic [OUT_PTR_W-1:0] wr_next;

	assign pop      = tokens.valid && tokens.ready;
	assign wr_next  = wr_q + 1'b1;
	assign space_ok = count_q <= OUT_CNT_W'(OUT_DEPTH - 2);

	// Head of the queue drives the output channel.
	assign tokens.valid        = count_q != '0;
	assign tokens.token_kind   = entry_q[rd_q].kind;
	assign tokens.token_start  = entry_q[rd_q].start;
	assign tokens.token_length = entry_q[rd_q].length;
	assign tokens.last_result  = entry_q[rd_q].last;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			entry_q[wr_q] <= push.r0;
		end
		if (push.count == 2'd2) begin
			entry_q[wr_next] <= push.r1;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + OUT_PTR_W'(push.count);
			rd_q    <= rd_q + OUT_PTR_W'(pop);
			count_q <= count_q + OUT_CNT_W'(push.count) - OUT_CNT_W'(pop);
		end
	end

endmodule

// ----- rtl/kls_checker.sv -----
// ----------------------------------------------------------------------------
// kls_checker
// Port-level checks on the token channel of the lexer.
// ----------------------------------------------------------------------------
module kls_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [kls_pkg::KIND_W-1:0] out_kind,
	input logic [kls_pkg::OFS_W-1:0]  out_start,
	input logic [kls_pkg::LEN_W-1:0]  out_length,
	input logic                      out_last
);
	import kls_pkg::*;

	// A stalled result stays offered and unchanged.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_start)
			&& $stable(out_length) && $stable(out_last))
		else $error("token result changed while stalled");

	// The end marker is empty and closes the stream.
	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == KIND_END |-> out_length == '0 && out_last)
		else $error("end marker with length or without last flag");

	// An error covers one byte and closes the stream.
	a_error: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == KIND_ERROR |-> out_length == LEN_W'(1) && out_last)
		else $error("error result malformed");

	// An arrow is always two characters.
	a_arrow: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == KIND_ARROW |-> out_length == LEN_W'(2))
		else $error("arrow result with wrong length");

endmodule

bind keyword_lexer_stream kls_checker u_kls_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (tokens.valid),
	.out_ready  (tokens.ready),
	.out_kind   (tokens.token_kind),
	.out_start  (tokens.token_start),
	.out_length (tokens.token_length),
	.out_last   (tokens.last_result)
);

// ----- verif/keyword_lexer_stream_tb.sv -----
// ----------------------------------------------------------------------------
// keyword_lexer_stream_tb
// Self-checking testbench for the streaming keyword lexer.
// ----------------------------------------------------------------------------
// Source bytes are sent on the text channel and every accepted byte is run
// through a software lexer in this file, which queues the tokens it expects.
// Each token word taken from the block is checked against the oldest queued
// token. Short directed texts come first. Random texts built from keywords,
// identifiers, numbers, symbols, arrows, blanks and stray bytes follow, under
// several idle patterns. A long output hold fills the block, and two long
// tokens sent back to back close the run.
// ----------------------------------------------------------------------------
module keyword_lexer_stream_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import kls_pkg::*;

	localparam int IDLE_LIMIT  = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int LONG_RUN    = 24;

	typedef enum logic [2:0] {
		SCAN_IDLE,
		SCAN_WORD,
		SCAN_NUMBER,
		SCAN_MINUS,
		SCAN_ERROR
	} scan_t;

	logic clk;
	logic arst_n;

	kls_in_if  text_ch();
	kls_out_if token_ch();

	keyword_lexer_stream u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_ch),
		.tokens (token_ch)
	);

	// State of the software lexer.
	scan_t               scan_state;
	logic [POS_BITS-1:0] text_pos;
	logic [POS_BITS-1:0] tok_begin;
	logic [LEN_W-1:0]    tok_len;
	logic [NUM_KW-1:0]   kw_alive;

	// Tokens predicted but not yet taken from the block.
	result_t pending_tokens[$];

	// Bytes of the random text being built.
	logic [7:0] stream_bytes[$];

	int errors;
	int idle_cycles;
	int send_gap_max;
	int take_gap_max;
	bit hold_request;

	// ------------------------------------------------------------------------
	// Keyword spellings and character classes
	// ------------------------------------------------------------------------

	function automatic logic [47:0] kw_spelling(int i);
		logic [47:0] s;
		case (i)
			0:       s = "func";
			1:       s = "return";
			2:       s = "var";
			3:       s = "i32";
			4:       s = "bool";
			5:       s = "true";
			default: s = "false";
		endcase
		return s;
	endfunction

	function automatic int kw_size(int i);
		int n;
		case (i)
			1:       n = 6;
			2, 3:    n = 3;
			6:       n = 5;
			default: n = 4;
		endcase
		return n;
	endfunction

	// Character k of keyword i, counted from the left.
	function automatic logic [7:0] kw_char(int i, int k);
		logic [47:0] s;
		s = kw_spelling(i);
		return s[8*(kw_size(i)-1-k) +: 8];
	endfunction

	function automatic bit is_letter(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic bit is_numeral(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit is_blank(logic [7:0] c);
		return c == " " || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic bit is_word_char(logic [7:0] c);
		return is_letter(c) || is_numeral(c) || c == "_";
	endfunction

	function automatic logic [KIND_W-1:0] symbol_kind(logic [7:0] c);
		logic [KIND_W-1:0] k;
		case (c)
			"(":     k = KIND_LPAREN;
			")":     k = KIND_RPAREN;
			"{":     k = KIND_LBRACE;
			"}":     k = KIND_RBRACE;
			"=":     k = KIND_EQUAL;
			":":     k = KIND_COLON;
			"+":     k = KIND_PLUS;
			";":     k = KIND_SEMI;
			default: k = KIND_ERROR;
		endcase
		return k;
	endfunction

	// Drop the keywords whose character at index idx differs from c.
	function automatic logic [NUM_KW-1:0] keep_keywords(logic [NUM_KW-1:0] alive,
			logic [LEN_W-1:0] idx, logic [7:0] c);
		logic [NUM_KW-1:0] m;
		m = '0;
		for (int i = 0; i < NUM_KW; i++) begin
			if (alive[i] && idx < kw_size(i) && kw_char(i, int'(idx)) == c) begin
				m[i] = 1'b1;
			end
		end
		return m;
	endfunction

	// ------------------------------------------------------------------------
	// Software lexer
	// ------------------------------------------------------------------------

	function automatic void push_token(logic [KIND_W-1:0] kind, logic [OFS_W-1:0] start,
			logic [LEN_W-1:0] length, logic last);
		result_t r;
		r.kind   = kind;
		r.start  = start;
		r.length = length;
		r.last   = last;
		pending_tokens.push_back(r);
	endfunction

	function automatic void reset_scan();
		scan_state = SCAN_IDLE;
		text_pos   = '0;
		tok_begin  = '0;
		kw_alive   = '1;
		tok_len    = '0;
	endfunction

	// Report the word, number or minus that is still open.
	function automatic void close_token();
		logic [KIND_W-1:0] kind;
		case (scan_state)
			SCAN_WORD: begin
				kind = KIND_IDENT;
				for (int i = 0; i < NUM_KW; i++) begin
					if (kw_alive[i] && tok_len == kw_size(i)) begin
						kind = KIND_KW0 + KIND_W'(i);
					end
				end
				push_token(kind, tok_begin, tok_len, 1'b0);
			end
			SCAN_NUMBER: begin
				push_token(KIND_NUMBER, tok_begin, tok_len, 1'b0);
			end
			SCAN_MINUS: begin
				push_token(KIND_MINUS, tok_begin, LEN_W'(1), 1'b0);
			end
			default: begin
			end
		endcase
		scan_state = SCAN_IDLE;
	endfunction

	// A byte seen between tokens.
	function automatic void begin_token(logic [7:0] c, logic [POS_BITS-1:0] p);
		logic [KIND_W-1:0] kind;
		scan_state = SCAN_IDLE;
		if (!is_blank(c)) begin
			tok_begin = p;
			if (is_letter(c) || c == "_") begin
				scan_state = SCAN_WORD;
				kw_alive   = keep_keywords('1, '0, c);
				tok_len    = LEN_W'(1);
			end else if (is_numeral(c)) begin
				scan_state = SCAN_NUMBER;
				tok_len    = LEN_W'(1);
			end else if (c == "-") begin
				scan_state = SCAN_MINUS;
			end else begin
				kind = symbol_kind(c);
				if (kind != KIND_ERROR) begin
					push_token(kind, p, LEN_W'(1), 1'b0);
				end else begin
					push_token(KIND_ERROR, p, LEN_W'(1), 1'b1);
					scan_state = SCAN_ERROR;
				end
			end
		end
	endfunction

	// Queue the tokens that one accepted source byte gives.
	function automatic void scan_byte(logic [7:0] c, bit eot);
		logic [POS_BITS-1:0] p;
		logic [POS_BITS-1:0] nxt;
		int                  n_prior;
		result_t             r;
		p       = text_pos;
		n_prior = pending_tokens.size();
		case (scan_state)
			SCAN_WORD: begin
				if (is_word_char(c)) begin
					kw_alive = keep_keywords(kw_alive, tok_len, c);
					if (tok_len != LEN_MAX) tok_len++;
				end else begin
					close_token();
					begin_token(c, p);
				end
			end
			SCAN_NUMBER: begin
				if (is_numeral(c)) begin
					if (tok_len != LEN_MAX) tok_len++;
				end else begin
					close_token();
					begin_token(c, p);
				end
			end
			SCAN_MINUS: begin
				if (c == ">") begin
					push_token(KIND_ARROW, tok_begin, LEN_W'(2), 1'b0);
					scan_state = SCAN_IDLE;
				end else begin
					close_token();
					begin_token(c, p);
				end
			end
			SCAN_ERROR: begin
			end
			default: begin
				begin_token(c, p);
			end
		endcase
		nxt = (p != POS_MAX) ? p + 1'b1 : p;

		// End of text flushes the open token and marks the final word.
		if (eot) begin
			if (scan_state != SCAN_ERROR) begin
				close_token();
				if (pending_tokens.size() == n_prior) begin
					push_token(KIND_END, nxt, '0, 1'b1);
				end else begin
					r      = pending_tokens.pop_back();
					r.last = 1'b1;
					pending_tokens.push_back(r);
				end
			end
			reset_scan();
		end else begin
			text_pos = nxt;
		end
	endfunction

	// ------------------------------------------------------------------------
	// Random text generation
	// ------------------------------------------------------------------------

	function automatic logic [7:0] random_word_char(bit lead);
		int r;
		r = $urandom_range(0, lead ? 52 : 62);
		if (r < 26) return 8'("a" + r);
		if (r < 52) return 8'("A" + r - 26);
		if (r == 52) return "_";
		return 8'("0" + r - 53);
	endfunction

	function automatic void append_token();
		int r;
		int kw;
		int n;
		r = $urandom_range(0, 99);
		if (r < 22) begin
			kw = $urandom_range(0, NUM_KW - 1);
			for (int k = 0; k < kw_size(kw); k++) stream_bytes.push_back(kw_char(kw, k));
		end else if (r < 38) begin
			// Identifiers often share a prefix with a keyword.
			kw = $urandom_range(0, NUM_KW - 1);
			n  = $urandom_range(0, kw_size(kw));
			for (int k = 0; k < n; k++) stream_bytes.push_back(kw_char(kw, k));
			if (n == 0) stream_bytes.push_back(random_word_char(1'b1));
			repeat ($urandom_range(0, 4)) stream_bytes.push_back(random_word_char(1'b0));
		end else if (r < 52) begin
			repeat ($urandom_range(1, 5)) stream_bytes.push_back(8'("0" + $urandom_range(0, 9)));
		end else if (r < 68) begin
			case ($urandom_range(0, 7))
				0:       stream_bytes.push_back("(");
				1:       stream_bytes.push_back(")");
				2:       stream_bytes.push_back("{");
				3:       stream_bytes.push_back("}");
				4:       stream_bytes.push_back("=");
				5:       stream_bytes.push_back(":");
				6:       stream_bytes.push_back("+");
				default: stream_bytes.push_back(";");
			endcase
		end else if (r < 75) begin
			stream_bytes.push_back("-");
			stream_bytes.push_back(">");
		end else if (r < 81) begin
			stream_bytes.push_back("-");
		end else if (r < 97) begin
			repeat ($urandom_range(1, 3)) begin
				n = $urandom_range(0, 5);
				stream_bytes.push_back(n == 0 ? 8'(" ") : 8'(8 + n));
			end
		end else begin
			stream_bytes.push_back(8'($urandom_range(0, 255)));
		end
		if ($urandom_range(0, 1) == 1) stream_bytes.push_back(" ");
	endfunction

	// ------------------------------------------------------------------------
	// Text channel driver
	// ------------------------------------------------------------------------

	// Offer one byte after a random gap and wait until it is taken.
	task automatic send_byte(logic [7:0] c, bit eot);
		int gap;
		gap = (send_gap_max > 0) ? $urandom_range(0, send_gap_max) : 0;
		repeat (gap) begin
			@(negedge clk);
			text_ch.valid <= 1'b0;
		end
		@(negedge clk);
		text_ch.valid       <= 1'b1;
		text_ch.byte_in     <= c;
		text_ch.end_of_text <= eot;
		@(posedge clk);
		while (!text_ch.ready) @(posedge clk);
		scan_byte(c, eot);
	endtask

	task automatic send_text(string s, bit eot_last);
		for (int i = 0; i < s.len(); i++) begin
			send_byte(s[i], eot_last && i == s.len() - 1);
		end
	endtask

	// Random texts, each closed by end of text on its last byte.
	task automatic run_random_texts(int items);
		int sent;
		sent = 0;
		while (sent < items) begin
			stream_bytes.delete();
			repeat ($urandom_range(1, 12)) append_token();
			for (int i = 0; i < stream_bytes.size(); i++) begin
				send_byte(stream_bytes[i], i == stream_bytes.size() - 1);
			end
			sent += stream_bytes.size();
		end
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// All symbols, arrow, lone minus, a trailing keyword and unknown bytes.
	task automatic test_directed();
		send_gap_max = 13;
		take_gap_max = 13;
		send_text("v1->2-(){}=:+;\t", 1'b1);
		send_text("true", 1'b1);
		send_byte(8'h80, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b1);
	endtask

	task automatic test_random_texts();
		send_gap_max = 13;
		take_gap_max = 13;
		run_random_texts(170);
		send_gap_max = 0;
		take_gap_max = 0;
		run_random_texts(110);
		take_gap_max = 13;
		run_random_texts(70);
		send_gap_max = 13;
		take_gap_max = 0;
		run_random_texts(60);
	endtask

	// The token side stops for a long stretch while bytes keep coming.
	task automatic test_output_hold();
		send_gap_max = 0;
		take_gap_max = 0;
		hold_request = 1'b1;
		send_text("(){}=:+;a;b;c;d;e;f;g;h;i;j;k;l;m;n", 1'b1);
		send_gap_max = 13;
		take_gap_max = 13;
	endtask

	// Long runs of one character give long words and numbers back to back.
	task automatic test_saturation();
		send_gap_max = 0;
		take_gap_max = 0;
		repeat (LONG_RUN) send_byte("x", 1'b0);
		send_text("+7  ", 1'b1);
		repeat (LONG_RUN) send_byte("9", 1'b0);
		send_text("- ", 1'b1);
	endtask

	// ------------------------------------------------------------------------
	// Clock, token side and checking
	// ------------------------------------------------------------------------

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Token receiver: random stalls, plus one long hold on request.
	initial begin : token_sink
		int gap;
		token_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			gap = (take_gap_max > 0) ? $urandom_range(0, take_gap_max) : 0;
			if (hold_request) begin
				gap          = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (gap > 0) begin
				@(negedge clk);
				token_ch.ready <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			@(negedge clk);
			token_ch.ready <= 1'b1;
			@(posedge clk);
			while (!token_ch.valid) @(posedge clk);
		end
	end

	// Compare each token word with the oldest prediction.
	always @(posedge clk) begin : token_check
		result_t got;
		result_t want;
		if (arst_n && token_ch.valid && token_ch.ready) begin
			got.kind   = token_ch.token_kind;
			got.start  = token_ch.token_start;
			got.length = token_ch.token_length;
			got.last   = token_ch.last_result;
			if (pending_tokens.size() == 0) begin
				errors++;
				$display("%0t: unexpected token, expected none, got kind %0d start %0d",
					$time, got.kind, got.start);
			end else begin
				want = pending_tokens.pop_front();
				if (got !== want) begin
					errors++;
					$display("%0t: expected kind %0d start %0d length %0d last %0d,",
						$time, want.kind, want.start, want.length, want.last);
					$display("%0t:      got kind %0d start %0d length %0d last %0d",
						$time, got.kind, got.start, got.length, got.last);
				end
			end
		end
	end

	// Stop a hung run: too many cycles without any word moving.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((text_ch.valid && text_ch.ready) || (token_ch.valid && token_ch.ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("keyword_lexer_stream: mismatch");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------------

	initial begin
		errors               = 0;
		idle_cycles          = 0;
		hold_request         = 1'b0;
		send_gap_max         = 13;
		take_gap_max         = 13;
		text_ch.valid        = 1'b0;
		text_ch.byte_in      = '0;
		text_ch.end_of_text  = 1'b0;
		arst_n               = 1'b0;
		reset_scan();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_random_texts();
		test_output_hold();
		test_saturation();

		// Let every predicted token arrive, then watch for strays.
		@(negedge clk);
		text_ch.valid <= 1'b0;
		while (pending_tokens.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		if (errors == 0) begin
			$display("keyword_lexer_stream: match");
		end else begin
			$display("keyword_lexer_stream: mismatch");
		end
		$finish;
	end

endmodule

// ----- keyword_lexer_stream.f -----
rtl/kls_pkg.sv
rtl/kls_if.sv
rtl/kls_core.sv
rtl/kls_out_fifo.sv
rtl/keyword_lexer_stream.sv
rtl/kls_checker.sv
verif/keyword_lexer_stream_tb.sv
